[hw/rtl/fpqdw_pkg.sv]
// ----------------------------------------------------------------------------
// fpqdw_pkg: shared types and constants
// Holds the item structs, the cell control struct and the sequencer states.
// ----------------------------------------------------------------------------
package fpqdw_pkg;

  localparam int MAX_ENTRIES = 64;
  // One spare cell holds the new packet before a drop brings the count back.
  localparam int NUM_CELLS   = MAX_ENTRIES + 1;
  localparam int CNT_W       = $clog2(NUM_CELLS + 1);
  localparam int BYTES_W     = 25;
  localparam int LIMIT_W     = 24;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd65536;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] OUTC_ENQ   = 2'd0;
  localparam logic [1:0] OUTC_DROP  = 2'd1;
  localparam logic [1:0] OUTC_DEQ   = 2'd2;
  localparam logic [1:0] OUTC_EMPTY = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [31:0] priority_req;
    logic [15:0] flow_id;
    logic [31:0] seq_number;
    logic [15:0] pkt_bytes;
    logic [15:0] pkt_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [15:0] out_tag;
    logic [15:0] out_flow;
    logic [31:0] out_seq;
    logic [15:0] out_bytes;
  } out_item_t;

  typedef struct packed {
    logic [31:0] prio;
    logic [15:0] flow;
    logic [31:0] seq;
    logic [15:0] bytes;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_ROTATE,
    CELL_SHIFT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic [CNT_W-1:0] occ;
    logic [CNT_W-1:0] pos;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIO,
    ST_SEQ,
    ST_REMOVE
  } state_t;

endpackage

[hw/rtl/fpqdw_cell.sv]
// ----------------------------------------------------------------------------
// fpqdw_cell: one slot of the arrival-ordered chain
// Loads a new entry, rotates toward the head, or closes a gap on removal.
// ----------------------------------------------------------------------------
module fpqdw_cell (
  input  logic                        clk,
  input  logic [fpqdw_pkg::CNT_W-1:0] idx,
  input  fpqdw_pkg::cell_ctrl_t       ctrl,
  input  fpqdw_pkg::entry_t           new_entry,
  input  fpqdw_pkg::entry_t           head_entry,
  input  fpqdw_pkg::entry_t           right_entry,
  output fpqdw_pkg::entry_t           entry
);
  import fpqdw_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctrl.cmd)
      CELL_HOLD: entry_nxt = entry_r;
      CELL_LOAD: begin
        if (idx == ctrl.occ) entry_nxt = new_entry;
      end
      CELL_ROTATE: begin
        // wrap the head back in at the tail of the held entries
        if (idx == ctrl.occ - 1'b1) entry_nxt = head_entry;
        else entry_nxt = right_entry;
      end
      CELL_SHIFT: begin
        if (idx >= ctrl.pos) entry_nxt = right_entry;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

[hw/rtl/fpqdw_ctrl.sv]
// ----------------------------------------------------------------------------
// fpqdw_ctrl: sequencer, victim search and result register
// Scans the head of the rotating chain for the best or worst entry.
// ----------------------------------------------------------------------------
module fpqdw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fpqdw_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fpqdw_pkg::out_item_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [23:0]           cfg_data,
  input  fpqdw_pkg::entry_t     head_entry,
  output fpqdw_pkg::entry_t     new_entry,
  output fpqdw_pkg::cell_ctrl_t cell_ctrl
);
  import fpqdw_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic               worst_r, worst_nxt;
  entry_t             best_r, best_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               in_fire;
  logic               out_free;
  logic [BYTES_W-1:0] sum_bytes;
  logic               take_prio;
  logic               take_seq;
  logic               last_step;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign sum_bytes = bytes_r + BYTES_W'(in_data.pkt_bytes);
  assign last_step = (cnt_r == occ_r - 1'b1);

  assign new_entry = '{prio: in_data.priority_req, flow: in_data.flow_id,
                       seq: in_data.seq_number, bytes: in_data.pkt_bytes,
                       tag: in_data.pkt_tag};

  assign take_prio = worst_r ? (head_entry.prio >= best_r.prio)
                             : (head_entry.prio <= best_r.prio);
  assign take_seq  = (head_entry.flow == best_r.flow) &&
                     (worst_r ? (head_entry.seq >= best_r.seq)
                              : (head_entry.seq <= best_r.seq));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.opcode == OP_ENQ) begin
            if ((sum_bytes > BYTES_W'(limit_r)) || (occ_r == CNT_W'(MAX_ENTRIES)))
              state_nxt = ST_PRIO;
          end else if (occ_r != '0) begin
            state_nxt = ST_PRIO;
          end
        end
      end
      ST_PRIO:   if (last_step) state_nxt = ST_SEQ;
      ST_SEQ:    if (last_step) state_nxt = ST_REMOVE;
      ST_REMOVE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    occ_nxt       = occ_r;
    bytes_nxt     = bytes_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    worst_nxt     = worst_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    cell_ctrl     = '{cmd: CELL_HOLD, occ: occ_r, pos: k_r};
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) begin
          if (in_data.opcode == OP_ENQ) begin
            cell_ctrl.cmd = CELL_LOAD;
            occ_nxt       = occ_r + 1'b1;
            bytes_nxt     = sum_bytes;
            worst_nxt     = 1'b1;
            if (!((sum_bytes > BYTES_W'(limit_r)) || (occ_r == CNT_W'(MAX_ENTRIES)))) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{outcome: OUTC_ENQ, default: '0};
            end
          end else begin
            worst_nxt = 1'b0;
            if (occ_r == '0) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{outcome: OUTC_EMPTY, default: '0};
            end
          end
        end
      end
      ST_PRIO: begin
        cell_ctrl.cmd = CELL_ROTATE;
        if (cnt_r == '0 || take_prio) begin
          best_nxt = head_entry;
          k_nxt    = cnt_r;
        end
        cnt_nxt = last_step ? '0 : cnt_r + 1'b1;
      end
      ST_SEQ: begin
        cell_ctrl.cmd = CELL_ROTATE;
        if (take_seq) begin
          best_nxt = head_entry;
          k_nxt    = cnt_r;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_REMOVE: begin
        if (out_free) begin
          cell_ctrl.cmd = CELL_SHIFT;
          occ_nxt       = occ_r - 1'b1;
          bytes_nxt     = bytes_r - BYTES_W'(best_r.bytes);
          out_valid_nxt = 1'b1;
          out_nxt       = '{outcome: worst_r ? OUTC_DROP : OUTC_DEQ,
                            out_tag: best_r.tag, out_flow: best_r.flow,
                            out_seq: best_r.seq, out_bytes: best_r.bytes};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      bytes_r     <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      bytes_r     <= bytes_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    worst_r <= worst_nxt;
    best_r  <= best_nxt;
    out_r   <= out_nxt;
  end

endmodule

[hw/rtl/flow_priority_queue_drop_worst.sv]
// ----------------------------------------------------------------------------
// flow_priority_queue_drop_worst: byte-limited priority packet queue
// Chain of slot cells in arrival order; drops the worst packet on overflow.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in_     | input     | in_valid / in_ready    | in_data  (in_item_t)
//  out_    | output    | out_valid / out_ready  | out_data (out_item_t)
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_data (byte limit, 24b)
//
// An enqueue without drop or an empty dequeue completes in the idle state.
// A drop or a dequeue rotates the chain once past the head comparator for
// the priority search, once for the sequence search in the chosen flow, then
// closes the gap in one shift. Reset clears the count, the byte total and
// the result valid, and loads the byte limit of 65536. A stalled result
// register holds the sequencer in its final step; the input is taken only
// when the result register is free. cfg_ready is always high.
//
module flow_priority_queue_drop_worst (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fpqdw_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fpqdw_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [23:0]          cfg_data
);
  import fpqdw_pkg::*;

  entry_t     cell_q [NUM_CELLS];
  entry_t     new_entry;
  cell_ctrl_t cell_ctrl;

  fpqdw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .head_entry (cell_q[0]),
    .new_entry  (new_entry),
    .cell_ctrl  (cell_ctrl)
  );

  // Each cell takes from its right neighbor; the last one has none and holds.
  genvar gi;
  generate
    for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
      if (gi < NUM_CELLS - 1) begin : g_mid
        fpqdw_cell u_cell (
          .clk         (clk),
          .idx         (CNT_W'(gi)),
          .ctrl        (cell_ctrl),
          .new_entry   (new_entry),
          .head_entry  (cell_q[0]),
          .right_entry (cell_q[gi+1]),
          .entry       (cell_q[gi])
        );
      end else begin : g_last
        fpqdw_cell u_cell (
          .clk         (clk),
          .idx         (CNT_W'(gi)),
          .ctrl        (cell_ctrl),
          .new_entry   (new_entry),
          .head_entry  (cell_q[0]),
          .right_entry (cell_q[gi]),
          .entry       (cell_q[gi])
        );
      end
    end
  endgenerate

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for flow_priority_queue_drop_worst
// Drives enqueue and dequeue transfers against a behavioral queue model and
// compares every result field by field, across byte limits and idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fpqdw_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  // covers a worst-case drop or dequeue, plus margin
  localparam int DRAIN_CYCLES   = 200;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [23:0] cfg_data;

  flow_priority_queue_drop_worst u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Queue model state: entries in arrival order, byte total and limit.
  entry_t      held_q[$];
  logic [24:0] held_bytes;
  logic [23:0] model_limit;

  out_item_t   expected_q[$];

  int          mismatch_cnt;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          recv_hold;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Find the worst (drop) or best (serve) entry; ties go to the latest.
  function automatic int pick_entry(bit worst);
    int k;
    logic [15:0] f;
    k = 0;
    for (int i = 1; i < held_q.size(); i++) begin
      if (worst ? (held_q[i].prio >= held_q[k].prio) : (held_q[i].prio <= held_q[k].prio))
        k = i;
    end
    f = held_q[k].flow;
    for (int i = 0; i < held_q.size(); i++) begin
      if (held_q[i].flow == f &&
          (worst ? (held_q[i].seq >= held_q[k].seq) : (held_q[i].seq <= held_q[k].seq)))
        k = i;
    end
    return k;
  endfunction

  // Advance the model by one accepted item and return its result.
  function automatic out_item_t queue_outcome(in_item_t it);
    out_item_t r;
    entry_t e;
    int k;
    r = '0;
    if (it.opcode == OP_ENQ) begin
      e.prio  = it.priority_req;
      e.flow  = it.flow_id;
      e.seq   = it.seq_number;
      e.bytes = it.pkt_bytes;
      e.tag   = it.pkt_tag;
      held_q.insert(held_q.size(), e);
      held_bytes += it.pkt_bytes;
      r.outcome = OUTC_ENQ;
      if (held_bytes > {1'b0, model_limit} || held_q.size() > MAX_ENTRIES) begin
        k = pick_entry(1'b1);
        r.outcome = OUTC_DROP;
      end else begin
        k = -1;
      end
    end else if (held_q.size() == 0) begin
      r.outcome = OUTC_EMPTY;
      k = -1;
    end else begin
      k = pick_entry(1'b0);
      r.outcome = OUTC_DEQ;
    end
    if (k >= 0) begin
      r.out_tag   = held_q[k].tag;
      r.out_flow  = held_q[k].flow;
      r.out_seq   = held_q[k].seq;
      r.out_bytes = held_q[k].bytes;
      held_bytes -= held_q[k].bytes;
      held_q.delete(k);
    end
    return r;
  endfunction

  // Check every result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result %p", out_data);
      end else begin
        out_item_t x;
        x = expected_q.pop_front();
        if (x.outcome !== out_data.outcome || x.out_tag !== out_data.out_tag ||
            x.out_flow !== out_data.out_flow || x.out_seq !== out_data.out_seq ||
            x.out_bytes !== out_data.out_bytes) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result mismatch: expected %p, got %p", x, out_data);
        end
      end
    end
  end

  // Receiver: stall at random, or hold off entirely while recv_hold is set.
  always @(posedge clk) begin
    if (!rst_n)
      out_ready <= 1'b0;
    else
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Send one item; the model sees it at its transfer. Valid stays high into
  // the next item unless the sender idles; wait_idle drops it.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(queue_outcome(it));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the byte limit while the block is idle.
  task automatic write_limit(logic [23:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    model_limit = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t make_enq(logic [31:0] p, logic [15:0] f, logic [31:0] s,
                                        logic [15:0] b, logic [15:0] t);
    in_item_t it;
    it.opcode = OP_ENQ;
    it.priority_req = p;
    it.flow_id = f;
    it.seq_number = s;
    it.pkt_bytes = b;
    it.pkt_tag = t;
    return it;
  endfunction

  function automatic in_item_t make_deq();
    in_item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.opcode = OP_DEQ;
    return it;
  endfunction

  // Random item: mostly small value sets so ties and shared flows happen.
  function automatic in_item_t rand_item(int deq_pct);
    in_item_t it;
    if ($urandom_range(99) < deq_pct)
      return make_deq();
    it = make_enq($urandom_range(3) == 0 ? $urandom : $urandom_range(7),
                  16'($urandom_range(3) == 0 ? $urandom : $urandom_range(3)),
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(15),
                  16'($urandom_range(4) == 0 ? $urandom : $urandom_range(4000)),
                  16'($urandom));
    return it;
  endfunction

  task automatic test_directed();
    send_item(make_deq());                                  // empty
    send_item(make_enq(32'h0, 16'h0, 32'h0, 16'h0, 16'h0)); // zero-size entry
    send_item(make_enq('1, '1, '1, '1, '1));
    send_item(make_enq(32'd5, 16'd1, 32'd9, 16'd100, 16'h1111));
    send_item(make_enq(32'd5, 16'd1, 32'd9, 16'd100, 16'h2222)); // tie
    send_item(make_enq(32'd5, 16'd1, 32'd3, 16'd100, 16'h3333));
    repeat (6) send_item(make_deq());                       // drain, then empty
    wait_idle();
    write_limit(24'd0);                                     // every nonzero-size enqueue drops
    send_item(make_enq(32'd1, 16'd2, 32'd3, 16'd0, 16'h4444)); // zero fits
    send_item(make_enq(32'd1, 16'd2, 32'd4, 16'd1, 16'h5555));
    send_item(make_deq());
    send_item(make_deq());
    write_limit(24'hFFFFFF);                                // store-full drops
    for (int i = 0; i < MAX_ENTRIES + 4; i++)
      send_item(make_enq(32'(i % 5), 16'(i % 3), 32'(i), 16'hFFFF, 16'(i)));
    write_limit(24'd1000);                                  // still over limit
    for (int i = 0; i < 4; i++)
      send_item(make_enq(32'd2, 16'd7, 32'(i), 16'd10, 16'(i)));
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct, int deq_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++)
      send_item(rand_item(deq_pct));
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Hold the receiver off for a long stretch while items keep coming.
  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        for (int i = 0; i < 40; i++)
          send_item(rand_item(30));
        in_valid <= 1'b0;
      end
      begin
        repeat (500) @(posedge clk);
        recv_hold = 1'b0;
      end
    join
    wait_idle();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    recv_hold = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_cnt   = 0;
    quiet_cycles   = 0;
    held_bytes     = '0;
    model_limit    = LIMIT_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    write_limit(24'd20000);
    test_random(400, 0, 0, 40);
    test_random(300, 85, 0, 45);
    write_limit(24'd5000);
    test_random(300, 0, 85, 40);
    test_backpressure();
    write_limit(24'hFFFFFF);
    test_random(300, 0, 0, 35);
    write_limit(LIMIT_RESET);
    test_random(300, 29, 29, 45);
    write_limit(24'd0);
    test_random(100, 0, 0, 30);
    wait_idle();

    if (mismatch_cnt == 0 && expected_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[flow_priority_queue_drop_worst.f]
hw/rtl/fpqdw_pkg.sv
hw/rtl/fpqdw_cell.sv
hw/rtl/fpqdw_ctrl.sv
hw/rtl/flow_priority_queue_drop_worst.sv
verif/tb.sv
